// File: rtl/core/biou_pkg.sv
`timescale 1ns / 1ps

package biou_pkg;

  localparam int COORD_BITS      = 16;
  localparam int RATIO_FRAC_BITS = 16;

  localparam int RATIO_W = RATIO_FRAC_BITS + 1;
  localparam int SPAN_W  = COORD_BITS + 1;
  localparam int AREA_W  = 2 * SPAN_W;
  localparam int OVL_W   = 2 * COORD_BITS;
  localparam int SUM_W   = 2 * COORD_BITS + 3;
  localparam int DEN_W   = 2 * COORD_BITS + 1;

  localparam logic [RATIO_W-1:0] RATIO_ONE     = RATIO_W'(1) << RATIO_FRAC_BITS;
  localparam logic [RATIO_W-1:0] THRESH_RESET  = RATIO_W'(1) << (RATIO_FRAC_BITS - 1);

  typedef struct packed {
    logic [COORD_BITS-1:0] a_left;
    logic [COORD_BITS-1:0] a_top;
    logic [COORD_BITS-1:0] a_right;
    logic [COORD_BITS-1:0] a_bottom;
    logic [COORD_BITS-1:0] b_left;
    logic [COORD_BITS-1:0] b_top;
    logic [COORD_BITS-1:0] b_right;
    logic [COORD_BITS-1:0] b_bottom;
  } box_pair_t;

  typedef struct packed {
    logic                       empty;
    logic                       one;
    logic [DEN_W-1:0]           den;
    logic [DEN_W-1:0]           rem;
    logic [RATIO_FRAC_BITS-1:0] q;
  } div_t;

endpackage

// File: rtl/core/biou_geom.sv
`timescale 1ns / 1ps

module biou_geom (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  biou_pkg::box_pair_t up_box,
  output logic               dn_valid,
  input  logic               dn_ready,
  output biou_pkg::div_t     dn_data
);

  localparam int CB  = biou_pkg::COORD_BITS;
  localparam int SW  = biou_pkg::SPAN_W;
  localparam int AW  = biou_pkg::AREA_W;
  localparam int OW  = biou_pkg::OVL_W;
  localparam int UW  = biou_pkg::SUM_W;
  localparam int DW  = biou_pkg::DEN_W;

  logic va_r, vb_r, vc_r;
  logic rdy_a, rdy_b, rdy_c;

  // stage a: intersection edges and spans
  logic [CB-1:0] il, it, ir, ib;
  logic [SW-1:0] iwd, ihd;
  logic [CB-1:0] iw_r, ih_r;
  logic [SW-1:0] aw_r, ah_r, bw_r, bh_r;

  // stage b: areas
  logic [OW-1:0]        ovl_r;
  logic signed [AW-1:0] area_a_r, area_b_r;

  // stage c: union and divider setup
  logic [UW-1:0] uni;
  logic          empty;
  logic [DW-1:0] den;
  biou_pkg::div_t div_r;

  assign rdy_c    = !vc_r || dn_ready;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign up_ready = rdy_a;
  assign dn_valid = vc_r;
  assign dn_data  = div_r;

  always_comb begin
    il  = (up_box.a_left  > up_box.b_left)   ? up_box.a_left   : up_box.b_left;
    it  = (up_box.a_top   > up_box.b_top)    ? up_box.a_top    : up_box.b_top;
    ir  = (up_box.a_right < up_box.b_right)  ? up_box.a_right  : up_box.b_right;
    ib  = (up_box.a_bottom < up_box.b_bottom) ? up_box.a_bottom : up_box.b_bottom;
    iwd = {1'b0, ir} - {1'b0, il};
    ihd = {1'b0, ib} - {1'b0, it};
  end

  always_comb begin
    uni = {{(UW-AW){area_a_r[AW-1]}}, area_a_r}
        + {{(UW-AW){area_b_r[AW-1]}}, area_b_r}
        - {{(UW-OW){1'b0}}, ovl_r};
    empty = uni[UW-1] || (uni == '0);
    den   = uni[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= up_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && up_valid) begin
      iw_r <= iwd[SW-1] ? '0 : iwd[CB-1:0];
      ih_r <= ihd[SW-1] ? '0 : ihd[CB-1:0];
      aw_r <= {1'b0, up_box.a_right}  - {1'b0, up_box.a_left};
      ah_r <= {1'b0, up_box.a_bottom} - {1'b0, up_box.a_top};
      bw_r <= {1'b0, up_box.b_right}  - {1'b0, up_box.b_left};
      bh_r <= {1'b0, up_box.b_bottom} - {1'b0, up_box.b_top};
    end
    if (rdy_b && va_r) begin
      ovl_r    <= OW'(iw_r) * OW'(ih_r);
      area_a_r <= AW'($signed(aw_r)) * AW'($signed(ah_r));
      area_b_r <= AW'($signed(bw_r)) * AW'($signed(bh_r));
    end
    if (rdy_c && vb_r) begin
      div_r.empty <= empty;
      div_r.one   <= !empty && ({{(DW-OW){1'b0}}, ovl_r} >= den);
      div_r.den   <= den;
      div_r.rem   <= {{(DW-OW){1'b0}}, ovl_r};
      div_r.q     <= '0;
    end
  end

endmodule

// File: rtl/core/biou_div_cell.sv
`timescale 1ns / 1ps

module biou_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  biou_pkg::div_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output biou_pkg::div_t dn_data
);

  localparam int DW = biou_pkg::DEN_W;
  localparam int QW = biou_pkg::RATIO_FRAC_BITS;

  logic           valid_r;
  biou_pkg::div_t data_r, data_nxt;
  logic [DW:0]    rem2, sub;
  logic           ge;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // one restoring division step
  always_comb begin
    rem2     = {up_data.rem, 1'b0};
    sub      = rem2 - {1'b0, up_data.den};
    ge       = (rem2 >= {1'b0, up_data.den});
    data_nxt = up_data;
    data_nxt.rem = ge ? sub[DW-1:0] : rem2[DW-1:0];
    data_nxt.q   = {up_data.q[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: rtl/core/box_iou_threshold_top.sv
`timescale 1ns / 1ps

// Intersection over union of two axis-aligned boxes with unsigned Q12.4 edges.
// One box pair is taken per clock while in_ready is high. The Q1.16 ratio (65536 =
// exactly one, truncated) passes through three geometry stages (intersection
// and spans, the three area multipliers, union and divider setup), sixteen
// divider cells of one quotient bit each, and the output register, which also
// compares the ratio against the threshold. A zero or negative union gives
// ratio 0 with union_empty set. The threshold (reset 0.5) may be written only
// while no item is in flight. Ready stalls only when every stage holds an item
// and the output is not taken.
module box_iou_threshold_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [biou_pkg::RATIO_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [biou_pkg::COORD_BITS-1:0]     in_a_left,
  input  logic [biou_pkg::COORD_BITS-1:0]     in_a_top,
  input  logic [biou_pkg::COORD_BITS-1:0]     in_a_right,
  input  logic [biou_pkg::COORD_BITS-1:0]     in_a_bottom,
  input  logic [biou_pkg::COORD_BITS-1:0]     in_b_left,
  input  logic [biou_pkg::COORD_BITS-1:0]     in_b_top,
  input  logic [biou_pkg::COORD_BITS-1:0]     in_b_right,
  input  logic [biou_pkg::COORD_BITS-1:0]     in_b_bottom,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [biou_pkg::RATIO_W-1:0]        out_ratio,
  output logic                                out_meets_threshold,
  output logic                                out_union_empty
);

  localparam int NC = biou_pkg::RATIO_FRAC_BITS;
  localparam int RW = biou_pkg::RATIO_W;

  biou_pkg::box_pair_t box;
  logic                chain_valid [NC+1];
  logic                chain_ready [NC+1];
  biou_pkg::div_t      chain_data  [NC+1];

  logic [RW-1:0] thr_r;
  logic          out_valid_r;
  logic [RW-1:0] ratio_r;
  logic          meets_r;
  logic          empty_r;
  logic          last_ready;
  logic [RW-1:0] ratio_nxt;

  assign box.a_left   = in_a_left;
  assign box.a_top    = in_a_top;
  assign box.a_right  = in_a_right;
  assign box.a_bottom = in_a_bottom;
  assign box.b_left   = in_b_left;
  assign box.b_top    = in_b_top;
  assign box.b_right  = in_b_right;
  assign box.b_bottom = in_b_bottom;

  biou_geom u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_box   (box),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    biou_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_data  (chain_data[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_data  (chain_data[i+1])
    );
  end

  assign last_ready      = !out_valid_r || out_ready;
  assign chain_ready[NC] = last_ready;

  always_comb begin
    if (chain_data[NC].empty) begin
      ratio_nxt = '0;
    end else if (chain_data[NC].one) begin
      ratio_nxt = biou_pkg::RATIO_ONE;
    end else begin
      ratio_nxt = {1'b0, chain_data[NC].q};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= biou_pkg::THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      if (last_ready) out_valid_r <= chain_valid[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (last_ready && chain_valid[NC]) begin
      ratio_r <= ratio_nxt;
      meets_r <= (ratio_nxt >= thr_r);
      empty_r <= chain_data[NC].empty;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ratio           = ratio_r;
  assign out_meets_threshold = meets_r;
  assign out_union_empty     = empty_r;

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_union_empty) |-> (out_ratio == '0))
    else $error("empty union with nonzero ratio");

  a_ratio_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ratio <= biou_pkg::RATIO_ONE))
    else $error("ratio above one");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output is free");

endmodule

// File: tb/iou_checker.sv
`timescale 1ns / 1ps

module iou_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [biou_pkg::RATIO_W-1:0] cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  biou_pkg::box_pair_t          in_pair,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [biou_pkg::RATIO_W-1:0] out_ratio,
  input  logic                         out_meets_threshold,
  input  logic                         out_union_empty,
  output int                           mismatches,
  output int                           outstanding,
  output int                           results_seen,
  output int                           empty_seen,
  output int                           matches_seen
);
  import biou_pkg::*;

  localparam int MAX_REPORTS = 30;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic               meets;
    logic               empty;
  } iou_result_t;

  iou_result_t        pending_ious[$];
  logic [RATIO_W-1:0] threshold;
  int                 bad_count;
  int                 result_count;
  int                 empty_count;
  int                 match_count;

  function automatic iou_result_t compute_iou(box_pair_t p, logic [RATIO_W-1:0] thresh);
    longint      al, at, ar, ab, bl, bt, br, bb;
    longint      iw, ih, overlap, uni, rem, q;
    iou_result_t r;
    al = longint'(p.a_left);
    at = longint'(p.a_top);
    ar = longint'(p.a_right);
    ab = longint'(p.a_bottom);
    bl = longint'(p.b_left);
    bt = longint'(p.b_top);
    br = longint'(p.b_right);
    bb = longint'(p.b_bottom);
    iw = ((ar < br) ? ar : br) - ((al > bl) ? al : bl);
    ih = ((ab < bb) ? ab : bb) - ((at > bt) ? at : bt);
    if (iw < 0) iw = 0;
    if (ih < 0) ih = 0;
    overlap = iw * ih;
    // inverted boxes keep their signed area
    uni = (ar - al) * (ab - at) + (br - bl) * (bb - bt) - overlap;
    q = 0;
    r.empty = (uni <= 0);
    if (!r.empty) begin
      if (overlap >= uni) begin
        q = longint'(RATIO_ONE);
      end else begin
        rem = overlap;
        for (int i = 0; i < RATIO_FRAC_BITS; i++) begin
          rem = rem << 1;
          q = q << 1;
          if (rem >= uni) begin
            rem = rem - uni;
            q = q | 1;
          end
        end
      end
    end
    r.ratio = q[RATIO_W-1:0];
    r.meets = (r.ratio >= thresh);
    return r;
  endfunction

  task automatic report(input string field, input longint want, input longint got);
    bad_count++;
    if (bad_count <= MAX_REPORTS) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    iou_result_t want;
    if (!rst_n) begin
      threshold = THRESH_RESET;
      pending_ious.delete();
      bad_count = 0;
      result_count = 0;
      empty_count = 0;
      match_count = 0;
    end else begin
      if (cfg_we) begin
        threshold = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        pending_ious.insert(pending_ious.size(), compute_iou(in_pair, threshold));
      end
      if (out_valid && out_ready) begin
        if (pending_ious.size() == 0) begin
          bad_count++;
          if (bad_count <= MAX_REPORTS) begin
            $display("%0t: unexpected item, expected none actual ratio %0d", $time, out_ratio);
          end
        end else begin
          want = pending_ious.pop_front();
          result_count++;
          if (want.empty) empty_count++;
          if (want.meets) match_count++;
          if (out_ratio !== want.ratio) begin
            report("ratio", longint'(want.ratio), longint'(out_ratio));
          end
          if (out_meets_threshold !== want.meets) begin
            report("meets_threshold", longint'(want.meets), longint'(out_meets_threshold));
          end
          if (out_union_empty !== want.empty) begin
            report("union_empty", longint'(want.empty), longint'(out_union_empty));
          end
        end
      end
    end
    mismatches   <= bad_count;
    outstanding  <= pending_ious.size();
    results_seen <= result_count;
    empty_seen   <= empty_count;
    matches_seen <= match_count;
  end

endmodule

// File: tb/box_iou_threshold_top_tb.sv
`timescale 1ns / 1ps

module box_iou_threshold_top_tb;
  import biou_pkg::*;

  localparam int          CYCLE_LIMIT = 300000;
  localparam int          COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 52;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [RATIO_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  box_pair_t          pair_drv = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [RATIO_W-1:0] out_ratio;
  logic               out_meets_threshold;
  logic               out_union_empty;

  int                 mismatches;
  int                 outstanding;
  int                 results_seen;
  int                 empty_seen;
  int                 matches_seen;

  int unsigned        cycle_count = 0;
  rx_mode_t           rx_mode = RX_OPEN;
  int                 rx_left = 0;
  logic [RATIO_W-1:0] phase_thresh [PHASES];

  box_iou_threshold_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_a_left           (pair_drv.a_left),
    .in_a_top            (pair_drv.a_top),
    .in_a_right          (pair_drv.a_right),
    .in_a_bottom         (pair_drv.a_bottom),
    .in_b_left           (pair_drv.b_left),
    .in_b_top            (pair_drv.b_top),
    .in_b_right          (pair_drv.b_right),
    .in_b_bottom         (pair_drv.b_bottom),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_ratio           (out_ratio),
    .out_meets_threshold (out_meets_threshold),
    .out_union_empty     (out_union_empty)
  );

  iou_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pair             (pair_drv),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_ratio           (out_ratio),
    .out_meets_threshold (out_meets_threshold),
    .out_union_empty     (out_union_empty),
    .mismatches          (mismatches),
    .outstanding         (outstanding),
    .results_seen        (results_seen),
    .empty_seen          (empty_seen),
    .matches_seen        (matches_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver back-pressure, switches among four patterns at random
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 120);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= cycle_count[2];
    endcase
  end

  function automatic logic [COORD_BITS-1:0] clip(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return '1;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic box_pair_t rand_pair();
    box_pair_t             p;
    int                    ax, ay, aw, ah, bx, by, bw, bh, kind;
    logic [COORD_BITS-1:0] t;
    kind = $urandom_range(0, 99);
    ax = $urandom_range(0, 62000);
    ay = $urandom_range(0, 62000);
    aw = $urandom_range(1, 3000);
    ah = $urandom_range(1, 3000);
    bw = $urandom_range(1, 3000);
    bh = $urandom_range(1, 3000);
    bx = ax;
    by = ay;
    if (kind < 40) begin
      // partial overlap
      bx = ax + $urandom_range(0, 2 * aw) - aw;
      by = ay + $urandom_range(0, 2 * ah) - ah;
    end else if (kind < 45) begin
      bw = aw;
      bh = ah;
    end else if (kind < 50) begin
      // second box nested in the first
      bx = ax + $urandom_range(0, aw / 2);
      by = ay + $urandom_range(0, ah / 2);
      bw = $urandom_range(0, aw - (bx - ax));
      bh = $urandom_range(0, ah - (by - ay));
    end else if (kind < 60) begin
      bx = ax + aw + $urandom_range(0, 500);
      by = $urandom_range(0, 62000);
    end else if (kind < 65) begin
      // both areas zero
      aw = 0;
      bh = 0;
    end else if (kind < 70) begin
      if ($urandom_range(0, 1) == 1) aw = 0;
      else ah = 0;
      bx = ax + $urandom_range(0, 200);
    end
    p.a_left   = clip(ax);
    p.a_top    = clip(ay);
    p.a_right  = clip(ax + aw);
    p.a_bottom = clip(ay + ah);
    p.b_left   = clip(bx);
    p.b_top    = clip(by);
    p.b_right  = clip(bx + bw);
    p.b_bottom = clip(by + bh);
    if (kind >= 70 && kind < 80) begin
      // inverted sides
      if ($urandom_range(0, 1) == 1) begin
        t = p.a_left;
        p.a_left = p.a_right;
        p.a_right = t;
      end
      if ($urandom_range(0, 1) == 1) begin
        t = p.a_top;
        p.a_top = p.a_bottom;
        p.a_bottom = t;
      end
      if ($urandom_range(0, 1) == 1) begin
        t = p.b_left;
        p.b_left = p.b_right;
        p.b_right = t;
      end
    end
    if (kind >= 80) begin
      p = {$urandom(), $urandom(), $urandom(), $urandom()};
    end
    return p;
  endfunction

  task automatic send_pair(input box_pair_t p);
    in_valid <= 1'b1;
    pair_drv <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [RATIO_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_pair(rand_pair());
        left--;
      end
      if ($urandom_range(0, 30) == 0) begin
        drain();
      end else if ($urandom_range(0, 7) == 0) begin
        hold_off($urandom_range(10, 25));
      end else if (burst != 40) begin
        hold_off($urandom_range(0, 5));
      end
    end
  endtask

  initial begin
    phase_thresh = '{17'd0, 17'd65536, 17'd1, 17'd131071, 17'd65535, 17'd32767,
                     17'd0, 17'd0};
    phase_thresh[6] = RATIO_W'($urandom_range(0, 65536));
    phase_thresh[7] = RATIO_W'($urandom_range(0, 131071));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pairs at the reset threshold of one half
    send_pair('{16'd0, 16'd0, 16'd16, 16'd16, 16'd0, 16'd0, 16'd16, 16'd16});
    send_pair('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    send_pair('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_pair('{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF});
    send_pair('{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd100, 16'd100, 16'd101, 16'd101});
    send_pair('{16'd0, 16'd0, 16'd16, 16'd16, 16'd32, 16'd32, 16'd48, 16'd48});
    send_pair('{16'd0, 16'd0, 16'd16, 16'd16, 16'd16, 16'd0, 16'd32, 16'd16});
    send_pair('{16'd0, 16'd0, 16'd32, 16'd16, 16'd16, 16'd0, 16'd48, 16'd16});
    send_pair('{16'd0, 16'd0, 16'd32, 16'd16, 16'd0, 16'd0, 16'd16, 16'd16});
    send_pair('{16'd0, 16'd0, 16'd32, 16'd16, 16'd0, 16'd1, 16'd16, 16'd16});
    send_pair('{16'd40, 16'd40, 16'd8, 16'd8, 16'd0, 16'd0, 16'd16, 16'd16});
    send_pair('{16'd0, 16'd40, 16'd40, 16'd8, 16'd0, 16'd0, 16'd4, 16'd4});
    send_pair('{16'd0, 16'd40, 16'd40, 16'd8, 16'd40, 16'd0, 16'd0, 16'd40});
    send_pair('{16'd10, 16'd0, 16'd10, 16'd50, 16'd0, 16'd0, 16'd20, 16'd20});
    send_pair('{16'd65000, 16'd65000, 16'hFFFF, 16'hFFFF,
                16'd65200, 16'd65200, 16'd65300, 16'd65300});
    send_pair('{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
                16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555});
    send_pair('{16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 16'd1});
    run_random(PHASE_ITEMS);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_threshold(phase_thresh[ph]);
      send_pair('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
      send_pair('{16'd8, 16'd8, 16'd24, 16'd24, 16'd8, 16'd8, 16'd24, 16'd24});
      run_random(PHASE_ITEMS);
    end

    drain();
    repeat (30) @(posedge clk);
    $display("checked %0d box pairs over %0d threshold settings including 0, 1.0 and 17-bit max",
             results_seen, PHASES + 1);
    $display("%0d pairs had an empty union, %0d met their threshold", empty_seen, matches_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/biou_pkg.sv
rtl/core/biou_geom.sv
rtl/core/biou_div_cell.sv
rtl/core/box_iou_threshold_top.sv
tb/iou_checker.sv
tb/box_iou_threshold_top_tb.sv
